// ===== hw/rtl/amt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the adaptive mean threshold block.
// No dependencies; every other file imports this package.
package amt_pkg;

  localparam int PIX_W  = 8;   // gray level and coordinate field width
  localparam int CFG_W  = 9;   // widest configuration register
  localparam int IDX_W  = 2;   // configuration register index
  localparam int CRD_W  = 10;  // internal coordinate width, holds row + radius
  localparam int RAD_W  = 4;   // window_radius register width
  localparam int QUO_W  = 8;   // quotient (mean) width
  localparam int STEP_W = 3;   // divide step counter, indexes QUO_W bits

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 15;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

  localparam logic [RAD_W-1:0] RST_RADIUS  = 4'd1;
  localparam logic [CFG_W-1:0] RST_EPSILON = 9'd0;
  localparam logic [CFG_W-1:0] RST_WIDTH   = 9'd256;
  localparam logic [CFG_W-1:0] RST_HEIGHT  = 9'd256;

  typedef enum logic [IDX_W-1:0] {
    REG_RADIUS  = 2'd0,
    REG_EPSILON = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

// ===== hw/rtl/amt_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel items and threshold results.
// Depends on amt_pkg for field widths.
interface amt_in_if import amt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel_row;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] gray_value;

  modport source (output valid, action, pixel_row, pixel_col, gray_value, input ready);
  modport sink   (input valid, action, pixel_row, pixel_col, gray_value, output ready);
endinterface

interface amt_out_if import amt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] binary_pixel;
  logic [PIX_W-1:0] window_mean;

  modport source (output valid, binary_pixel, window_mean, input ready);
  modport sink   (input valid, binary_pixel, window_mean, output ready);
endinterface

// ===== hw/rtl/amt_alu.sv =====
`timescale 1ns / 1ps
// Shared add/subtract unit: accumulates window pixels and runs divide steps.
// Depends on amt_pkg for the operation code.
module amt_alu import amt_pkg::*; #(
  parameter int W = 18
) (
  input  alu_op_t        op,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   res,
  output logic           borrow
);

  logic [W:0] full;

  always_comb begin
    unique case (op)
      ALU_ADD: full = {1'b0, a} + {1'b0, b};
      ALU_SUB: full = {1'b0, a} - {1'b0, b};
      default: full = '0;
    endcase
  end

  assign res    = full[W-1:0];
  assign borrow = (op == ALU_SUB) ? full[W] : 1'b0;

endmodule

// ===== hw/rtl/amt_frame.sv =====
`timescale 1ns / 1ps
// Gray frame store: one write port, one registered read port.
// Depends on amt_pkg for the pixel width.
module amt_frame import amt_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/adaptive_mean_threshold.sv =====
`timescale 1ns / 1ps
// Adaptive mean threshold top level: sequencer, config registers, result register.
// Depends on amt_pkg, amt_ifs, amt_alu and amt_frame.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    action, pixel_row, pixel_col, gray_value
//   out_chan  out  valid/ready    binary_pixel, window_mean
//   cfg_*     in   cfg_we only    cfg_index, cfg_data
//
// A write leaves in_chan ready. A query holds in_chan off from its transfer until
// its result is loaded, for a clipped window of N pixels: a setup state, N frame
// store reads into the shared adder, a drain state, 8 restoring divide steps on
// the same unit and a load state. Synchronous active-low reset clears
// control and config; the frame store holds no reset and needs no clearing pass.
// A finished result waits in the output register without blocking new items; a
// later query stalls in its load cycle until that register is taken.
module adaptive_mean_threshold import amt_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic             clk,
  input  logic             rst_n,
  amt_in_if.sink           in_chan,
  amt_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIDE   = 2 * MAX_RADIUS + 1;
  localparam int CNT_W  = $clog2(SIDE * SIDE + 1);
  localparam int ALU_W  = CNT_W + QUO_W;  // sum stays below 256 * count

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_SCAN, ST_DRAIN, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RK_NONE, RK_CENTER, RK_WIN
  } rd_kind_t;

  // Configuration registers
  logic [RAD_W-1:0] radius_r;
  logic [CFG_W-1:0] epsilon_r;
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RST_RADIUS;
      epsilon_r <= RST_EPSILON;
      width_r   <= RST_WIDTH;
      height_r  <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RADIUS:  radius_r  <= cfg_data[RAD_W-1:0];
        REG_EPSILON: epsilon_r <= cfg_data;
        REG_WIDTH:   width_r   <= cfg_data;
        REG_HEIGHT:  height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective dimensions and radius
  logic [CRD_W-1:0] w_eff, h_eff, r_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = CRD_W'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = CRD_W'(MAX_WIDTH);
    end else begin
      w_eff = CRD_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = CRD_W'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = CRD_W'(MAX_HEIGHT);
    end else begin
      h_eff = CRD_W'(height_r);
    end
    if (32'(radius_r) > MAX_RADIUS) begin
      r_eff = CRD_W'(MAX_RADIUS);
    end else begin
      r_eff = CRD_W'(radius_r);
    end
  end

  // Clamped input coordinates
  logic [CRD_W-1:0] in_row, in_col, w_last, h_last;

  assign w_last = w_eff - CRD_W'(1);
  assign h_last = h_eff - CRD_W'(1);
  assign in_row = (CRD_W'(in_chan.pixel_row) > h_last) ? h_last : CRD_W'(in_chan.pixel_row);
  assign in_col = (CRD_W'(in_chan.pixel_col) > w_last) ? w_last : CRD_W'(in_chan.pixel_col);

  function automatic logic [AW-1:0] pix_addr(input logic [CRD_W-1:0] row,
                                             input logic [CRD_W-1:0] col);
    logic [31:0] lin;
    lin = 32'(row) * 32'(MAX_WIDTH) + 32'(col);
    return lin[AW-1:0];
  endfunction

  // Sequencer state
  state_t            state_r;
  rd_kind_t          rd_kind_r;
  logic [CRD_W-1:0]  row_r, col_r;
  logic [CRD_W-1:0]  bot_r, lft_r, rgt_r;
  logic [CRD_W-1:0]  i_r, j_r;
  logic [CNT_W-1:0]  count_r;
  logic [ALU_W-1:0]  sum_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic [PIX_W-1:0]  center_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_bin_r, out_mean_r;

  logic in_xfer, out_free;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // Window bounds from the latched center
  logic [CRD_W-1:0] top_c, bot_c, lft_c, rgt_c, row_hi, col_hi;

  assign row_hi = row_r + r_eff;
  assign col_hi = col_r + r_eff;
  assign top_c  = (row_r > r_eff) ? row_r - r_eff : '0;
  assign lft_c  = (col_r > r_eff) ? col_r - r_eff : '0;
  assign bot_c  = (row_hi > h_last) ? h_last : row_hi;
  assign rgt_c  = (col_hi > w_last) ? w_last : col_hi;

  // Frame store
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [PIX_W-1:0] mem_rdata;

  assign mem_re    = (state_r == ST_SETUP) || (state_r == ST_SCAN);
  assign mem_raddr = (state_r == ST_SETUP) ? pix_addr(row_r, col_r) : pix_addr(i_r, j_r);

  amt_frame #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame (
    .clk   (clk),
    .we    (in_xfer && (action_t'(in_chan.action) == ACT_WRITE)),
    .waddr (pix_addr(in_row, in_col)),
    .wdata (in_chan.gray_value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Shared arithmetic unit: add during the scan, subtract during the divide
  alu_op_t          alu_op;
  logic [ALU_W-1:0] alu_b, alu_res;
  logic             alu_borrow;

  assign alu_op = (state_r == ST_DIV) ? ALU_SUB : ALU_ADD;
  assign alu_b  = (state_r == ST_DIV) ? (ALU_W'(count_r) << step_r) : ALU_W'(mem_rdata);

  amt_alu #(
    .W (ALU_W)
  ) u_alu (
    .op     (alu_op),
    .a      (sum_r),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // Threshold decision: black when mean - epsilon > center pixel
  logic signed [CRD_W:0] diff_c;
  assign diff_c = $signed({3'b000, quo_r}) - $signed({{(CRD_W + 1 - CFG_W){epsilon_r[CFG_W-1]}},
                                                       epsilon_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_kind_r   <= RK_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      // pixel read issued last cycle lands now
      unique case (rd_kind_r)
        RK_CENTER: center_r <= mem_rdata;
        RK_WIN:    sum_r    <= alu_res;
        default: ;
      endcase

      unique case (state_r)
        ST_IDLE: begin
          rd_kind_r <= RK_NONE;
          if (in_xfer && (action_t'(in_chan.action) == ACT_QUERY)) begin
            row_r   <= in_row;
            col_r   <= in_col;
            sum_r   <= '0;
            count_r <= '0;
            quo_r   <= '0;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          bot_r     <= bot_c;
          lft_r     <= lft_c;
          rgt_r     <= rgt_c;
          i_r       <= top_c;
          j_r       <= lft_c;
          rd_kind_r <= RK_CENTER;
          state_r   <= ST_SCAN;
        end
        ST_SCAN: begin
          rd_kind_r <= RK_WIN;
          count_r   <= count_r + CNT_W'(1);
          if (j_r == rgt_r) begin
            j_r <= lft_r;
            if (i_r == bot_r) begin
              state_r <= ST_DRAIN;
            end else begin
              i_r <= i_r + CRD_W'(1);
            end
          end else begin
            j_r <= j_r + CRD_W'(1);
          end
        end
        ST_DRAIN: begin
          rd_kind_r <= RK_NONE;
          step_r    <= STEP_W'(QUO_W - 1);
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          if (!alu_borrow) begin
            sum_r         <= alu_res;
            quo_r[step_r] <= 1'b1;
          end
          if (step_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_mean_r  <= quo_r;
            out_bin_r   <= (diff_c > $signed({3'b000, center_r})) ? PIX_BLACK : PIX_WHITE;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.binary_pixel = out_bin_r;
  assign out_chan.window_mean  = out_mean_r;

  // Assertions
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (action_t'(in_chan.action) == ACT_WRITE) && !out_valid_r) |=> !out_valid_r)
    else $error("write transfer produced a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (action_t'(in_chan.action) == ACT_QUERY)) |=> !in_chan.ready)
    else $error("input accepted during a query");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (count_r != '0))
    else $error("divide started with an empty window");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished query did not load the result register");

endmodule
